>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication sampled on the rising clock edge, off while reset is high.
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> hw/rtl/stcr_pkg.sv
// Types, codes and helper functions for the serial timer command receiver.
// No dependencies; imported by every design module of the block (not by the checker).
`timescale 1ns / 1ps
`default_nettype none

package stcr_pkg;

   // Receive phase codes
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_PRE  = 3'd1;
   localparam logic [2:0] PH_MAIN = 3'd2;
   localparam logic [2:0] PH_COOL = 3'd3;
   localparam logic [2:0] PH_SUM  = 3'd4;

   // Command opcodes (bits 2..0 of a command byte)
   localparam logic [2:0] OP_STATUS   = 3'd0;
   localparam logic [2:0] OP_START    = 3'd1;
   localparam logic [2:0] OP_ARM_PRE  = 3'd2;
   localparam logic [2:0] OP_ARM_COOL = 3'd3;
   localparam logic [2:0] OP_ARM_MAIN = 3'd5;

   localparam logic [6:0] TIME_MAX     = 7'd99;
   localparam logic [6:0] SUM_OFFSET   = 7'd5;
   localparam logic [3:0] NODE_ADDR_RST = 4'd14;

   // CSR register indexes
   localparam logic REG_NODE_ADDRESS = 1'b0;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_error;
      logic [1:0] status_code;
      logic [6:0] current_time;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } stage_type;

   // Binary to BCD for 0..255: {hundreds, tens, ones}
   function automatic logic [11:0] bin_to_bcd(input logic [7:0] v);
      logic [15:0] prod;
      logic [4:0]  q10;
      logic [1:0]  hund;
      logic [3:0]  tens;
      logic [3:0]  ones;
      prod = 16'(v) * 16'd205;         // v / 10 exact over the whole byte
      q10  = prod[15:11];
      ones = 4'(v - 8'(q10) * 8'd10);
      if (q10 >= 5'd20) begin
         hund = 2'd2;
      end else if (q10 >= 5'd10) begin
         hund = 2'd1;
      end else begin
         hund = 2'd0;
      end
      tens = 4'(q10 - 5'(hund) * 5'd10);
      return {2'b00, hund, tens, ones};
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stcr_in_reg.sv
// Input register of the command receiver: captures one transaction a cycle unless stalled.
// Depends on stcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stcr_in_reg import stcr_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire item_type  req_item,
   input  wire logic      advance,
   output stage_type      stage
);

   logic     valid_ff;
   item_type item_ff;

   // Hold only when full and the execute stage cannot move.
   assign req_stall = valid_ff & ~advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

`default_nettype wire

>>> hw/rtl/stcr_csr.sv
// APB-style configuration register block: holds the node address.
// Depends on stcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stcr_csr import stcr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic [3:0]       node_address
);

   logic [3:0] node_address_ff;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff <= NODE_ADDR_RST;
      end else if (wr_en && csr_paddr[2] == REG_NODE_ADDRESS) begin
         node_address_ff <= csr_pwdata[3:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_NODE_ADDRESS: csr_prdata = {28'd0, node_address_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign node_address = node_address_ff;

endmodule

`default_nettype wire

>>> hw/rtl/stcr_exec.sv
// Execute stage: command decode, receive phase, time registers, result register.
// Depends on stcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stcr_exec import stcr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire stage_type  stage,
   input  wire logic [3:0] node_address,
   output logic            advance,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_tx_valid,
   output logic            rsp_tx_port,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_start_pulse,
   output logic            rsp_load_pulse,
   output logic            rsp_link_refresh,
   output logic [7:0]      rsp_pre_time_out,
   output logic [7:0]      rsp_main_time_out,
   output logic [7:0]      rsp_cool_time_out
);

   logic [2:0] phase_ff, phase_in;
   logic [7:0] pend_pre_ff, pend_pre_in;
   logic [7:0] pend_main_ff, pend_main_in;
   logic [7:0] pend_cool_ff, pend_cool_in;
   logic [7:0] comm_pre_ff, comm_pre_in;
   logic [7:0] comm_main_ff, comm_main_in;
   logic [7:0] comm_cool_ff, comm_cool_in;

   logic       out_valid_ff;
   logic       tx_valid_ff, tx_valid_in;
   logic       tx_port_ff, tx_port_in;
   logic [7:0] tx_byte_ff, tx_byte_in;
   logic       start_ff, start_in;
   logic       load_ff, load_in;
   logic       refresh_ff, refresh_in;

   logic       fire;
   logic [7:0] b;
   logic [6:0] time_sat;
   logic [11:0] time_bcd;
   logic [11:0] main_bcd;
   logic [7:0] cool_sel;
   logic [6:0] checksum;
   logic [7:0] main_dec;

   assign advance = ~out_valid_ff | ~rsp_stall;
   assign fire    = stage.valid & advance;
   assign b       = stage.item.rx_byte;

   assign time_sat = (stage.item.current_time > TIME_MAX) ? TIME_MAX
                                                          : stage.item.current_time;
   assign time_bcd = bin_to_bcd({1'b0, time_sat});

   // On the cool payload the checksum already covers the new cool time.
   assign cool_sel = (phase_ff == PH_COOL) ? b : pend_cool_ff;
   assign main_bcd = bin_to_bcd(pend_main_ff);
   assign checksum = 7'(pend_pre_ff[6:0] + cool_sel[6:0] - main_bcd[6:0] - SUM_OFFSET);

   // high digit * 10 + low digit, no digit check
   assign main_dec = 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);

   always_comb begin
      phase_in     = phase_ff;
      pend_pre_in  = pend_pre_ff;
      pend_main_in = pend_main_ff;
      pend_cool_in = pend_cool_ff;
      comm_pre_in  = comm_pre_ff;
      comm_main_in = comm_main_ff;
      comm_cool_in = comm_cool_ff;
      tx_valid_in  = 1'b0;
      tx_port_in   = 1'b0;
      tx_byte_in   = 8'd0;
      start_in     = 1'b0;
      load_in      = 1'b0;
      refresh_in   = 1'b0;

      if (stage.item.rx_error) begin
         phase_in = PH_IDLE;
      end else if (b[7]) begin
         if (b[6:3] == node_address) begin
            refresh_in = 1'b1;
            unique case (b[2:0])
               OP_STATUS: begin
                  tx_valid_in = 1'b1;
                  tx_byte_in  = {stage.item.status_code, 6'd0} | time_bcd[7:0];
               end
               OP_START: begin
                  start_in    = 1'b1;
                  comm_pre_in = 8'd0;
               end
               OP_ARM_PRE:  phase_in = PH_PRE;
               OP_ARM_MAIN: phase_in = PH_MAIN;
               OP_ARM_COOL: phase_in = PH_COOL;
               default: ;
            endcase
         end
      end else begin
         unique case (phase_ff)
            PH_SUM: begin
               if (b == {1'b0, checksum}) begin
                  comm_pre_in  = pend_pre_ff;
                  comm_main_in = pend_main_ff;
                  comm_cool_in = pend_cool_ff;
                  load_in      = 1'b1;
               end
               phase_in = PH_IDLE;
            end
            PH_PRE: begin
               pend_pre_in = b;
               phase_in    = PH_IDLE;
            end
            PH_MAIN: begin
               pend_main_in = main_dec;
               phase_in     = PH_IDLE;
            end
            PH_COOL: begin
               pend_cool_in = b;
               phase_in     = PH_SUM;
               tx_valid_in  = 1'b1;
               tx_port_in   = 1'b1;
               tx_byte_in   = {1'b0, checksum};
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pend_pre_ff  <= 8'd0;
         pend_main_ff <= 8'd0;
         pend_cool_ff <= 8'd0;
         comm_pre_ff  <= 8'd0;
         comm_main_ff <= 8'd0;
         comm_cool_ff <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= stage.valid;
         end
         if (fire) begin
            phase_ff     <= phase_in;
            pend_pre_ff  <= pend_pre_in;
            pend_main_ff <= pend_main_in;
            pend_cool_ff <= pend_cool_in;
            comm_pre_ff  <= comm_pre_in;
            comm_main_ff <= comm_main_in;
            comm_cool_ff <= comm_cool_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         tx_valid_ff <= tx_valid_in;
         tx_port_ff  <= tx_port_in;
         tx_byte_ff  <= tx_byte_in;
         start_ff    <= start_in;
         load_ff     <= load_in;
         refresh_ff  <= refresh_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_tx_valid      = tx_valid_ff;
   assign rsp_tx_port       = tx_port_ff;
   assign rsp_tx_byte       = tx_byte_ff;
   assign rsp_start_pulse   = start_ff;
   assign rsp_load_pulse    = load_ff;
   assign rsp_link_refresh  = refresh_ff;
   // Committed times settle with the result register on the same edge.
   assign rsp_pre_time_out  = comm_pre_ff;
   assign rsp_main_time_out = comm_main_ff;
   assign rsp_cool_time_out = comm_cool_ff;

endmodule

`default_nettype wire

>>> hw/rtl/serial_timer_command_receiver_unit.sv
// Serial timer command receiver, top level: input register, execute stage, CSRs.
// Depends on stcr_pkg, stcr_in_reg, stcr_exec, stcr_csr.
// Takes one received byte per transaction and returns one result per transaction.
// A transaction is accepted every cycle while rsp_stall stays low; it is captured in
// the input register, and its result is loaded into the result register when the
// execute stage advances. Decode and receive-phase update are combinational between
// the two registers, which sets that rate. When the result is stalled the input
// register still takes one more transaction. node_address lies at byte address 0
// and resets to 14; write it only while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module serial_timer_command_receiver_unit import stcr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_rx_error,
   input  wire logic [1:0]  req_status_code,
   input  wire logic [6:0]  req_current_time,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_tx_valid,
   output logic             rsp_tx_port,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_start_pulse,
   output logic             rsp_load_pulse,
   output logic             rsp_link_refresh,
   output logic [7:0]       rsp_pre_time_out,
   output logic [7:0]       rsp_main_time_out,
   output logic [7:0]       rsp_cool_time_out,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   item_type   req_item;
   stage_type  stage;
   logic       advance;
   logic [3:0] node_address;

   assign req_item.rx_byte      = req_rx_byte;
   assign req_item.rx_error     = req_rx_error;
   assign req_item.status_code  = req_status_code;
   assign req_item.current_time = req_current_time;

   stcr_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .advance   (advance),
      .stage     (stage)
   );

   stcr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .node_address (node_address)
   );

   stcr_exec u_exec (
      .clock             (clock),
      .reset             (reset),
      .stage             (stage),
      .node_address      (node_address),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_port       (rsp_tx_port),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_start_pulse   (rsp_start_pulse),
      .rsp_load_pulse    (rsp_load_pulse),
      .rsp_link_refresh  (rsp_link_refresh),
      .rsp_pre_time_out  (rsp_pre_time_out),
      .rsp_main_time_out (rsp_main_time_out),
      .rsp_cool_time_out (rsp_cool_time_out)
   );

endmodule

`default_nettype wire

>>> hw/rtl/stcr_checker.sv
// Port-level checker for the serial timer command receiver, plus its bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stcr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_tx_valid,
   input wire logic        rsp_tx_port,
   input wire logic [7:0]  rsp_tx_byte,
   input wire logic        rsp_start_pulse,
   input wire logic        rsp_load_pulse,
   input wire logic [7:0]  rsp_pre_time_out
);

   // Stalled result transaction keeps its valid and its reply byte.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_tx_byte), "result dropped while stalled")

   // A checksum echo is only seven bits wide.
   `ASSERT_IMPL(a_echo_7bit, clock, reset, rsp_valid && rsp_tx_valid && rsp_tx_port, rsp_tx_byte[7] == 1'b0, "checksum echo wider than 7 bits")

   // Start clears the committed pre time in the same result.
   `ASSERT_IMPL(a_start_clears, clock, reset, rsp_valid && rsp_start_pulse, rsp_pre_time_out == 8'd0, "pre time not cleared by start")

   // A reply, a start and a load never come from one byte.
   `ASSERT_CLK(a_excl_events, clock, reset, !rsp_valid || $onehot0({rsp_tx_valid, rsp_start_pulse, rsp_load_pulse}), "conflicting result events")

   // No reply means a zero reply byte and port.
   `ASSERT_IMPL(a_idle_reply, clock, reset, rsp_valid && !rsp_tx_valid, rsp_tx_byte == 8'd0 && rsp_tx_port == 1'b0, "reply fields set without a reply")

endmodule

bind serial_timer_command_receiver_unit stcr_checker u_stcr_checker (.*);

`default_nettype wire
